[rtl/core/sspr_pkg.sv]
// Shared types and constants for the servo status packet receiver.
// Used by sspr_ram users and by the top level; depends on nothing.
`default_nettype none

package sspr_pkg;

	localparam int MAX_PAYLOAD = 16;
	localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] LEN_MIN   = 8'd2;
	localparam logic [7:0] LEN_MAX   = 8'(MAX_PAYLOAD + 2);

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TIMEOUT = 3'd1,
		ST_WRONGID = 3'd2,
		ST_BADLEN  = 3'd3,
		ST_CHKSUM  = 3'd4,
		ST_SERVO   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SYNC = 3'd1,
		PH_ID   = 3'd2,
		PH_LEN  = 3'd3,
		PH_ERR  = 3'd4,
		PH_DATA = 3'd5,
		PH_CHK  = 3'd6,
		PH_EMIT = 3'd7
	} phase_t;

	typedef struct packed {
		status_t             status;
		logic [7:0]          data_byte;
		logic [PAY_AW-1:0]   data_index;
		logic                data_valid;
		logic [CNT_W-1:0]    data_count;
		logic [7:0]          servo_error;
		logic                last;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/sspr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module sspr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/core/servo_status_packet_receiver.sv]
// Servo status packet receiver: one result word per failure or empty reply, one word per payload
// byte on success. A failure or empty reply word is valid in the cycle after the word that causes
// it is taken; the first payload word follows a RAM read and an output load after the checksum
// word. Throughput: one input word a cycle while the output is free; each payload byte takes a
// RAM read, then an output load, and the burst holds off input until its last word is loaded.
// Reset clears all control state; the payload RAM is not cleared and is only read after being written.
`default_nettype none

module servo_status_packet_receiver
	import sspr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [7:0] byte_value, [15:8] servo_id, [31:16] timeout_ticks
	input  wire logic [31:0] s_axis_tdata,
	// [1:0] operation
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] status, [10:3] data_byte, [14:11] data_index, [19:15] data_count,
	// [27:20] servo_error, [31:28] zero
	output logic [31:0]      m_axis_tdata,
	// [0] data_valid
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);

	phase_t            phase_q, phase_d;
	logic              hdr_q, hdr_d;
	logic [7:0]        wanted_id_q, wanted_id_d;
	logic [CNT_W-1:0]  data_len_q, data_len_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        err_q, err_d;
	logic [CNT_W-1:0]  rcvd_q, rcvd_d;
	logic [15:0]       ticks_q, ticks_d;
	logic [PAY_AW-1:0] emit_idx_q, emit_idx_d;
	logic              fetched_q, fetched_d;
	logic              out_valid_q, out_valid_d;
	result_t           out_q, out_d;

	logic              accept;
	logic              out_free;
	op_t               op;
	logic [7:0]        in_byte;
	logic [15:0]       tick_dec;
	logic              ram_we;
	logic [7:0]        ram_rdata;

	assign op       = op_t'(s_axis_tuser);
	assign in_byte  = s_axis_tdata[7:0];
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (phase_q != PH_EMIT) && out_free;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign tick_dec = (ticks_q != 16'd0) ? ticks_q - 16'd1 : ticks_q;

	// Writes land only in the data phase and reads only during the burst,
	// which starts after the checksum word, so the two never touch one entry.
	assign ram_we = accept && (op == OP_BYTE) && (phase_q == PH_DATA)
		&& (rcvd_q < CNT_W'(MAX_PAYLOAD));

	sspr_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rcvd_q[PAY_AW-1:0]),
		.wdata (in_byte),
		.raddr (emit_idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		phase_d     = phase_q;
		hdr_d       = hdr_q;
		wanted_id_d = wanted_id_q;
		data_len_d  = data_len_q;
		sum_d       = sum_q;
		err_d       = err_q;
		rcvd_d      = rcvd_q;
		ticks_d     = ticks_q;
		emit_idx_d  = emit_idx_q;
		fetched_d   = fetched_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_d       = out_q;

		// failure word template: current error byte, single-word run
		if (accept) begin
			out_d.data_byte   = 8'd0;
			out_d.data_index  = '0;
			out_d.data_valid  = 1'b0;
			out_d.data_count  = '0;
			out_d.servo_error = err_q;
			out_d.last        = 1'b1;
			out_d.status      = ST_OK;
			case (op)
				OP_START: begin
					wanted_id_d = s_axis_tdata[15:8];
					ticks_d     = s_axis_tdata[31:16];
					hdr_d       = 1'b0;
					data_len_d  = '0;
					sum_d       = 8'd0;
					err_d       = 8'd0;
					rcvd_d      = '0;
					phase_d     = PH_SYNC;
					if (s_axis_tdata[31:16] == 16'd0) begin
						out_d.status      = ST_TIMEOUT;
						out_d.servo_error = 8'd0;
						out_valid_d       = 1'b1;
						phase_d           = PH_IDLE;
					end
				end
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						ticks_d = tick_dec;
						if (tick_dec == 16'd0) begin
							out_d.status = ST_TIMEOUT;
							out_valid_d  = 1'b1;
							phase_d      = PH_IDLE;
						end
					end
				end
				OP_BYTE: begin
					case (phase_q)
						PH_SYNC: begin
							if (in_byte == SYNC_BYTE) begin
								hdr_d = 1'b1;
								if (hdr_q) begin
									phase_d = PH_ID;
								end
							end else begin
								hdr_d = 1'b0;
							end
						end
						PH_ID: begin
							sum_d   = in_byte;
							phase_d = PH_LEN;
						end
						PH_LEN: begin
							if (sum_q != wanted_id_q) begin
								out_d.status = ST_WRONGID;
								out_valid_d  = 1'b1;
								phase_d      = PH_IDLE;
							end else if (in_byte < LEN_MIN || in_byte > LEN_MAX) begin
								out_d.status = ST_BADLEN;
								out_valid_d  = 1'b1;
								phase_d      = PH_IDLE;
							end else begin
								data_len_d = CNT_W'(in_byte - LEN_MIN);
								sum_d      = sum_q + in_byte;
								phase_d    = PH_ERR;
							end
						end
						PH_ERR: begin
							err_d   = in_byte;
							sum_d   = sum_q + in_byte;
							rcvd_d  = '0;
							phase_d = (data_len_q != '0) ? PH_DATA : PH_CHK;
						end
						PH_DATA: begin
							sum_d  = sum_q + in_byte;
							rcvd_d = rcvd_q + CNT_W'(1);
							if (rcvd_q + CNT_W'(1) >= data_len_q) begin
								phase_d = PH_CHK;
							end
						end
						PH_CHK: begin
							phase_d = PH_IDLE;
							if (~sum_q != in_byte) begin
								out_d.status = ST_CHKSUM;
								out_valid_d  = 1'b1;
							end else if (err_q != 8'd0) begin
								out_d.status = ST_SERVO;
								out_valid_d  = 1'b1;
							end else if (data_len_q == '0) begin
								out_valid_d = 1'b1;
							end else begin
								// hand over to the burst; first read issues next cycle
								emit_idx_d = '0;
								fetched_d  = 1'b0;
								phase_d    = PH_EMIT;
							end
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_EMIT) begin
			if (!fetched_q) begin
				fetched_d = 1'b1;
			end else if (out_free) begin
				out_d.status      = ST_OK;
				out_d.data_byte   = ram_rdata;
				out_d.data_index  = emit_idx_q;
				out_d.data_valid  = 1'b1;
				out_d.data_count  = data_len_q;
				out_d.servo_error = err_q;
				out_d.last        = ({1'b0, emit_idx_q} + CNT_W'(1)) == data_len_q;
				out_valid_d       = 1'b1;
				fetched_d         = 1'b0;
				emit_idx_d        = emit_idx_q + PAY_AW'(1);
				if (({1'b0, emit_idx_q} + CNT_W'(1)) == data_len_q) begin
					phase_d = PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_q       <= 1'b0;
			wanted_id_q <= 8'd0;
			data_len_q  <= '0;
			sum_q       <= 8'd0;
			err_q       <= 8'd0;
			rcvd_q      <= '0;
			ticks_q     <= 16'd0;
			emit_idx_q  <= '0;
			fetched_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hdr_q       <= hdr_d;
			wanted_id_q <= wanted_id_d;
			data_len_q  <= data_len_d;
			sum_q       <= sum_d;
			err_q       <= err_d;
			rcvd_q      <= rcvd_d;
			ticks_q     <= ticks_d;
			emit_idx_q  <= emit_idx_d;
			fetched_q   <= fetched_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= out_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.servo_error, out_q.data_count, out_q.data_index,
		out_q.data_byte, out_q.status};
	assign m_axis_tuser  = out_q.data_valid;
	assign m_axis_tlast  = out_q.last;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.data_valid) |-> ({1'b0, out_q.data_index} < out_q.data_count))
		else $error("payload index beyond payload length");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.data_valid && out_q.last)
			|-> (({1'b0, out_q.data_index} + CNT_W'(1)) == out_q.data_count))
		else $error("last flag not on final payload byte");

	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_OK) |-> (out_q.last && !out_q.data_valid))
		else $error("failure word is not a single-word run");

	a_burst_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (phase_q != PH_EMIT))
		else $error("burst still running after last word taken");

endmodule

`default_nettype wire
